>>> hw/rtl/ssr_pkg.sv
package ssr_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BURST_DEPTH     = 8;
    localparam int LEN_W           = 4;
    localparam int IDX_W           = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int WORD_W          = 64;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN   = 2'd3;

    // Eight byte lanes, lane 0 in the lowest bits
    typedef logic [BURST_DEPTH-1:0][7:0] byte_vec_t;

    // Group of results caused by one input transaction
    typedef struct packed {
        byte_vec_t        bytes;
        logic [LEN_W-1:0] cnt;      // number of results, 0 means none
        logic             end_flag; // last result closes the string
        logic             bare;     // single end marker without a byte
    } burst_t;

endpackage

>>> hw/rtl/ssr_window.sv
module ssr_window
    import ssr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,
    input  logic             fill_clear,
    input  logic [LEN_W-1:0] plen,
    input  logic [LEN_W-1:0] rlen,
    input  byte_vec_t        pattern,
    input  byte_vec_t        replacement,
    output burst_t           burst
);

    byte_vec_t        win_reg;
    byte_vec_t        win_next;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;

    byte_vec_t        win_w;
    logic [IDX_W-1:0] wr_pos;
    logic [LEN_W-1:0] new_fill;
    logic             hit;
    logic             full;

    // Write the new byte into the window and compare against the pattern
    always_comb begin
        wr_pos   = (fill_reg >= plen) ? '0 : fill_reg[IDX_W-1:0];
        win_w    = win_reg;
        win_w[wr_pos] = text_byte;
        new_fill = {1'b0, wr_pos} + LEN_W'(1);
        full     = (new_fill == plen);
        hit      = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LEN_W'(i) < plen) && (win_w[i] != pattern[i])) begin
                hit = 1'b0;
            end
        end
    end

    // Decide the results and the next window state
    always_comb begin
        burst     = '0;
        win_next  = win_reg;
        fill_next = fill_reg;
        if (accept) begin
            win_next  = win_w;
            fill_next = new_fill;
            if (full && hit) begin
                fill_next      = '0;
                burst.end_flag = end_of_text;
                if (rlen == '0) begin
                    // deletion: only a bare end marker on the final byte
                    burst.cnt  = end_of_text ? LEN_W'(1) : '0;
                    burst.bare = end_of_text;
                end else begin
                    burst.bytes = replacement;
                    burst.cnt   = rlen;
                end
            end else if (full && !end_of_text) begin
                // no match: emit oldest byte and slide
                burst.bytes[0] = win_w[0];
                burst.cnt      = LEN_W'(1);
                for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                    win_next[i] = win_w[i+1];
                end
                fill_next = plen - LEN_W'(1);
            end else if (end_of_text) begin
                // final byte: flush what the window holds
                burst.bytes    = win_w;
                burst.cnt      = new_fill;
                burst.end_flag = 1'b1;
                fill_next      = '0;
            end
        end
        if (fill_clear) begin
            fill_next = '0;
        end
    end

    // Window contents need no reset: only filled entries are read
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

>>> hw/rtl/stream_substring_replace_unit.sv
// A result reaches the m_ channel from its input transaction through the burst register, then the output register.
// Throughput: one input transaction per cycle while each yields at most one result and the output is not stalled;
// an item that expands to n results holds the burst register until all n have moved to the output register.
// Reset (aresetn low, synchronous): channels empty, window emptied, pattern_len = 1,
// other configuration registers and burst index 0; window bytes, burst contents and output data are not cleared.
module stream_substring_replace_unit
    import ssr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] text_byte
    input  logic                 s_tlast,   // end_of_text
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic                 m_tuser,   // [0] byte_present
    output logic                 m_tlast,   // end_of_result
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0] pattern_reg;
    logic [LEN_W-1:0]  plen_reg;
    logic [WORD_W-1:0] repl_reg;
    logic [LEN_W-1:0]  rlen_reg;

    logic [LEN_W-1:0]  plen_eff;
    logic [LEN_W-1:0]  rlen_eff;
    logic              cfg_wr;
    logic              plen_wr;

    burst_t            new_burst;
    burst_t            burst_reg;
    logic              burst_valid_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              s_accept;
    logic              move;
    logic              last_beat;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_present_reg;
    logic              out_last_reg;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign plen_wr   = cfg_wr && (cfg_index == CFG_PATTERN_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            plen_reg    <= LEN_W'(1);
            repl_reg    <= '0;
            rlen_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_PATTERN_BYTES:     pattern_reg <= cfg_data;
                CFG_PATTERN_LEN:       plen_reg    <= cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES: repl_reg    <= cfg_data;
                CFG_REPLACEMENT_LEN:   rlen_reg    <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp lengths to the supported range
    always_comb begin
        if (plen_reg == '0) begin
            plen_eff = LEN_W'(1);
        end else if (plen_reg > LEN_W'(MAX_PATTERN)) begin
            plen_eff = LEN_W'(MAX_PATTERN);
        end else begin
            plen_eff = plen_reg;
        end
        rlen_eff = (rlen_reg > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : rlen_reg;
    end

    ssr_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .fill_clear  (plen_wr),
        .plen        (plen_eff),
        .rlen        (rlen_eff),
        .pattern     (byte_vec_t'(pattern_reg)),
        .replacement (byte_vec_t'(repl_reg)),
        .burst       (new_burst)
    );

    // Handshake between burst register and output register
    assign move      = burst_valid_reg && (!out_valid_reg || m_tready);
    assign last_beat = ({1'b0, idx_reg} == (burst_reg.cnt - LEN_W'(1)));
    assign s_tready  = !burst_valid_reg || (move && last_beat);
    assign s_accept  = s_tvalid && s_tready;

    // Burst register: holds the results of one item until all are sent
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end else if (s_accept) begin
            burst_valid_reg <= (new_burst.cnt != '0);
            idx_reg         <= '0;
        end else if (move) begin
            if (last_beat) begin
                burst_valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            burst_reg <= new_burst;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_byte_reg    <= burst_reg.bytes[idx_reg];
            out_present_reg <= !burst_reg.bare;
            out_last_reg    <= burst_reg.end_flag && last_beat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_present_reg;
    assign m_tlast  = out_last_reg;

    // A held burst never runs past its count
    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_valid_reg |-> ({1'b0, idx_reg} < burst_reg.cnt))
        else $error("burst index beyond count");

    // Empty bursts are never held
    a_burst_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_valid_reg |-> (burst_reg.cnt != '0))
        else $error("empty burst held");

    // Input only stalls behind a pending burst
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> burst_valid_reg)
        else $error("input stalled with no burst pending");

    // A bare end marker always closes the string
    a_bare_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("bare marker without end flag");

endmodule
